// ----- rtl/fct_pkg.sv -----
// shared types, codes and constants of the file table
package fct_pkg;

	localparam int CLUSTER_COUNT_DEF = 256;
	localparam int SLOT_COUNT_DEF    = 4;
	localparam int BYTES_PER_CLUSTER = 4;
	localparam int FIRST_USABLE      = 2;
	localparam int BASE_YEAR         = 1980;
	localparam logic [15:0] CHAIN_END_MARK = 16'hffff;

	typedef enum logic [2:0] {
		ACT_CREATE  = 3'd0,
		ACT_WRITE   = 3'd1,
		ACT_PUT     = 3'd2,
		ACT_DELETE  = 3'd3,
		ACT_RD_HDR  = 3'd4,
		ACT_RD_NEXT = 3'd5
	} act_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_W_RD,
		ST_W_CHK,
		ST_W_END,
		ST_PUT_FIN,
		ST_DEL_RD,
		ST_DEL_CHK,
		ST_RN_FIN,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic fail;
		logic create;
		logic write_init;
		logic scan_rd;
		logic scan_take;
		logic scan_skip;
		logic write_end;
		logic put;
		logic put_fin;
		logic del_init;
		logic del_rd;
		logic del_chk;
		logic rd_hdr;
		logic rn;
		logic rn_fin;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		act_t act;
		logic hit;
		logic empty_ok;
		logic space_ok;
		logic wc_open;
		logic rc_open;
		logic scan_free;
		logic need_one;
		logic del_go;
		logic del_stop;
	} stat_t;

endpackage

// ----- rtl/fct_ram.sv -----
// generic simple dual-port ram with registered read
module fct_ram
	#(
		parameter int WIDTH = 16,
		parameter int DEPTH = 256
	)
	(
		input  logic                     clk,
		input  logic                     we,
		input  logic [$clog2(DEPTH)-1:0] waddr,
		input  logic [WIDTH-1:0]         wdata,
		input  logic [$clog2(DEPTH)-1:0] raddr,
		output logic [WIDTH-1:0]         rdata
	);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/fct_ctrl.sv -----
// request sequencer of the file table
module fct_ctrl
	import fct_pkg::*;
	(
		input  logic  clk,
		input  logic  arst_n,
		input  logic  s_tvalid,
		output logic  s_tready,
		output logic  m_tvalid,
		input  logic  m_tready,
		input  stat_t stat,
		output cmd_t  cmd
	);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				state_d = ST_RESP;
				case (stat.act)
					ACT_WRITE: begin
						if (stat.hit && stat.space_ok) state_d = ST_W_RD;
					end
					ACT_PUT: begin
						if (stat.wc_open) state_d = ST_PUT_FIN;
					end
					ACT_DELETE: begin
						if (stat.hit) state_d = ST_DEL_RD;
					end
					ACT_RD_NEXT: begin
						if (stat.rc_open) state_d = ST_RN_FIN;
					end
					default: state_d = ST_RESP;
				endcase
			end
			ST_W_RD:  state_d = ST_W_CHK;
			ST_W_CHK: begin
				state_d = (stat.scan_free && stat.need_one) ? ST_W_END : ST_W_RD;
			end
			ST_W_END:   state_d = ST_RESP;
			ST_PUT_FIN: state_d = ST_RESP;
			ST_DEL_RD:  state_d = stat.del_go ? ST_DEL_CHK : ST_RESP;
			ST_DEL_CHK: state_d = stat.del_stop ? ST_RESP : ST_DEL_RD;
			ST_RN_FIN:  state_d = ST_RESP;
			ST_RESP: begin
				if (m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr = 1'b1;
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_DECODE: begin
				case (stat.act)
					ACT_CREATE: begin
						cmd.create = stat.empty_ok && stat.space_ok;
						cmd.fail   = !(stat.empty_ok && stat.space_ok);
					end
					ACT_WRITE: begin
						cmd.write_init = stat.hit && stat.space_ok;
						cmd.fail       = !(stat.hit && stat.space_ok);
					end
					ACT_PUT: begin
						cmd.put  = stat.wc_open;
						cmd.fail = !stat.wc_open;
					end
					ACT_DELETE: begin
						cmd.del_init = stat.hit;
						cmd.fail     = !stat.hit;
					end
					ACT_RD_HDR: begin
						cmd.rd_hdr = stat.hit;
						cmd.fail   = !stat.hit;
					end
					ACT_RD_NEXT: begin
						cmd.rn   = stat.rc_open;
						cmd.fail = !stat.rc_open;
					end
					default: cmd.fail = 1'b1;
				endcase
			end
			ST_W_RD:  cmd.scan_rd = 1'b1;
			ST_W_CHK: begin
				cmd.scan_take = stat.scan_free;
				cmd.scan_skip = !stat.scan_free;
			end
			ST_W_END:   cmd.write_end = 1'b1;
			ST_PUT_FIN: cmd.put_fin = 1'b1;
			ST_DEL_RD:  cmd.del_rd = stat.del_go;
			ST_DEL_CHK: cmd.del_chk = 1'b1;
			ST_RN_FIN:  cmd.rn_fin = 1'b1;
			ST_RESP:    m_tvalid = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

// ----- rtl/fct_dp.sv -----
// directory slots, allocation table, cluster store and result word
module fct_dp
	import fct_pkg::*;
	#(
		parameter int CLUSTER_COUNT = CLUSTER_COUNT_DEF,
		parameter int SLOT_COUNT    = SLOT_COUNT_DEF
	)
	(
		input  logic         clk,
		input  logic         arst_n,
		input  cmd_t         cmd,
		output stat_t        stat,
		input  logic [143:0] s_tdata,
		input  logic [2:0]   s_tuser,
		output logic         res_ok,
		output logic [15:0]  res_date,
		output logic [15:0]  res_time,
		output logic [31:0]  res_size,
		output logic [7:0]   res_first,
		output logic [31:0]  res_word,
		output logic         res_end
	);

	localparam int AW = $clog2(CLUSTER_COUNT);
	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	function automatic logic usable(input logic [15:0] v);
		return (v >= 16'(FIRST_USABLE)) && (v < 16'(CLUSTER_COUNT));
	endfunction

	// request word
	act_t        req_act_q;
	logic [63:0] req_name_q;
	logic [9:0]  req_bytes_q;
	logic [15:0] req_date_q;
	logic [15:0] req_time_q;
	logic [31:0] req_data_q;

	logic [63:0]   slot_name_q  [SLOT_COUNT];
	logic [15:0]   slot_date_q  [SLOT_COUNT];
	logic [15:0]   slot_time_q  [SLOT_COUNT];
	logic [31:0]   slot_size_q  [SLOT_COUNT];
	logic [AW-1:0] slot_start_q [SLOT_COUNT];

	logic [15:0]   c_q;
	logic [AW-1:0] prev_q;
	logic          prev_vld_q;
	logic [AW-1:0] start_q;
	logic [8:0]    need_q;
	logic [AW:0]   steps_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] free_q;
	logic [SW-1:0] sel_q;
	logic          wc_open_q, rc_open_q;
	logic [AW-1:0] wc_q, rc_q;

	logic          hit, empty_ok;
	logic [SW-1:0] hit_idx, empty_idx;
	logic [10:0]   bytes_up;
	logic [8:0]    need_req;

	logic          a_we;
	logic [AW-1:0] a_waddr, a_raddr;
	logic [15:0]   a_wdata, a_rdata;
	logic [31:0]   c_rdata;

	// lowest matching slot and lowest empty slot
	always_comb begin
		hit       = 1'b0;
		hit_idx   = '0;
		empty_ok  = 1'b0;
		empty_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (slot_name_q[i][7:0] != 8'd0 && slot_name_q[i] == req_name_q) begin
				hit     = 1'b1;
				hit_idx = SW'(i);
			end
			if (slot_name_q[i][7:0] == 8'd0) begin
				empty_ok  = 1'b1;
				empty_idx = SW'(i);
			end
		end
	end

	assign bytes_up = {1'b0, req_bytes_q} + 11'(BYTES_PER_CLUSTER - 1);
	assign need_req = (bytes_up[10:2] == 9'd0) ? 9'd1 : bytes_up[10:2];

	assign stat.clr_last  = (clr_q == AW'(CLUSTER_COUNT - 1));
	assign stat.act       = req_act_q;
	assign stat.hit       = hit;
	assign stat.empty_ok  = empty_ok;
	assign stat.space_ok  = (16'(free_q) >= 16'(need_req));
	assign stat.wc_open   = wc_open_q;
	assign stat.rc_open   = rc_open_q;
	assign stat.scan_free = (a_rdata == 16'd0);
	assign stat.need_one  = (need_q == 9'd1);
	assign stat.del_go    = usable(c_q) && (steps_q < (AW + 1)'(CLUSTER_COUNT));
	assign stat.del_stop  = (a_rdata == CHAIN_END_MARK) || (a_rdata == 16'd0);

	// allocation table port selection
	always_comb begin
		a_we    = 1'b0;
		a_waddr = c_q[AW-1:0];
		a_wdata = 16'd0;
		if (cmd.clr) begin
			a_we    = 1'b1;
			a_waddr = clr_q;
		end else if (cmd.scan_take) begin
			a_we    = prev_vld_q;
			a_waddr = prev_q;
			a_wdata = c_q;
		end else if (cmd.write_end) begin
			a_we    = 1'b1;
			a_waddr = prev_q;
			a_wdata = CHAIN_END_MARK;
		end else if (cmd.del_chk) begin
			a_we = 1'b1;
		end
	end

	always_comb begin
		a_raddr = c_q[AW-1:0];
		if (cmd.put) a_raddr = wc_q;
		else if (cmd.rn) a_raddr = rc_q;
	end

	fct_ram #(.WIDTH(16), .DEPTH(CLUSTER_COUNT)) u_alloc (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	fct_ram #(.WIDTH(32), .DEPTH(CLUSTER_COUNT)) u_store (
		.clk   (clk),
		.we    (cmd.put),
		.waddr (wc_q),
		.wdata (req_data_q),
		.raddr (rc_q),
		.rdata (c_rdata)
	);

	// request capture, date and time packed on the way in
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_act_q   <= act_t'(s_tuser);
			req_name_q  <= s_tdata[63:0];
			req_bytes_q <= s_tdata[73:64];
			req_date_q  <= ((16'(s_tdata[85:74]) - 16'(BASE_YEAR)) << 9)
				+ (16'(s_tdata[89:86]) << 5) + 16'(s_tdata[94:90]);
			req_time_q  <= (16'(s_tdata[99:95]) << 11) + (16'(s_tdata[105:100]) << 5)
				+ 16'(s_tdata[111:107]);
			req_data_q  <= s_tdata[143:112];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_name_q[i]  <= '0;
				slot_date_q[i]  <= '0;
				slot_time_q[i]  <= '0;
				slot_size_q[i]  <= '0;
				slot_start_q[i] <= '0;
			end
			c_q        <= '0;
			prev_q     <= '0;
			prev_vld_q <= 1'b0;
			start_q    <= '0;
			need_q     <= '0;
			steps_q    <= '0;
			clr_q      <= '0;
			free_q     <= AW'(CLUSTER_COUNT - FIRST_USABLE);
			sel_q      <= '0;
			wc_open_q  <= 1'b0;
			rc_open_q  <= 1'b0;
			wc_q       <= '0;
			rc_q       <= '0;
			res_ok     <= 1'b0;
			res_date   <= '0;
			res_time   <= '0;
			res_size   <= '0;
			res_first  <= '0;
			res_word   <= '0;
			res_end    <= 1'b0;
		end else begin
			if (cmd.clr) clr_q <= clr_q + AW'(1);
			if (cmd.fail || cmd.create || cmd.put || cmd.del_init || cmd.rn
				|| cmd.write_init) begin
				res_ok    <= cmd.create || cmd.del_init;
				res_date  <= '0;
				res_time  <= '0;
				res_size  <= '0;
				res_first <= '0;
				res_word  <= '0;
				res_end   <= 1'b0;
			end
			if (cmd.create) slot_name_q[empty_idx] <= req_name_q;
			if (cmd.write_init) begin
				sel_q      <= hit_idx;
				c_q        <= 16'(FIRST_USABLE);
				prev_vld_q <= 1'b0;
				need_q     <= need_req;
			end
			if (cmd.scan_take) begin
				if (!prev_vld_q) start_q <= c_q[AW-1:0];
				prev_q     <= c_q[AW-1:0];
				prev_vld_q <= 1'b1;
				need_q     <= need_q - 9'd1;
				free_q     <= free_q - AW'(1);
				c_q        <= c_q + 16'd1;
			end
			if (cmd.scan_skip) c_q <= c_q + 16'd1;
			if (cmd.write_end) begin
				slot_date_q[sel_q]  <= req_date_q;
				slot_time_q[sel_q]  <= req_time_q;
				slot_size_q[sel_q]  <= 32'(req_bytes_q);
				slot_start_q[sel_q] <= start_q;
				wc_q      <= start_q;
				wc_open_q <= 1'b1;
				res_ok    <= 1'b1;
				res_date  <= req_date_q;
				res_time  <= req_time_q;
				res_size  <= 32'(req_bytes_q);
				res_first <= 8'(start_q);
			end
			if (cmd.put_fin) begin
				wc_open_q <= usable(a_rdata);
				wc_q      <= a_rdata[AW-1:0];
				res_ok    <= 1'b1;
				res_end   <= !usable(a_rdata);
			end
			if (cmd.del_init) begin
				slot_name_q[hit_idx][7:0] <= 8'd0;
				c_q       <= 16'(slot_start_q[hit_idx]);
				steps_q   <= '0;
				wc_open_q <= 1'b0;
				rc_open_q <= 1'b0;
			end
			if (cmd.del_chk) begin
				// an entry already free adds nothing to the free total
				if (a_rdata != 16'd0) free_q <= free_q + AW'(1);
				c_q     <= a_rdata;
				steps_q <= steps_q + (AW + 1)'(1);
			end
			if (cmd.rd_hdr) begin
				rc_open_q <= usable(16'(slot_start_q[hit_idx]));
				rc_q      <= slot_start_q[hit_idx];
				res_ok    <= 1'b1;
				res_date  <= slot_date_q[hit_idx];
				res_time  <= slot_time_q[hit_idx];
				res_size  <= slot_size_q[hit_idx];
				res_first <= 8'(slot_start_q[hit_idx]);
				res_word  <= '0;
				res_end   <= 1'b0;
			end
			if (cmd.rn_fin) begin
				rc_open_q <= usable(a_rdata);
				rc_q      <= a_rdata[AW-1:0];
				res_ok    <= 1'b1;
				res_word  <= c_rdata;
				res_end   <= !usable(a_rdata);
			end
		end
	end

endmodule

// ----- rtl/fat_chain_file_table_top.sv -----
// FAT-style file table: a directory of named slots over a linked cluster table.
// One request is handled at a time; the next word is taken once the result has been
// taken. After reset the allocation table is swept free, one entry a cycle, before
// the first request is accepted. Create, read header and failing requests go from
// decode straight to the result; put data and read next first pass a finishing
// state. Write scans the allocation table from cluster 2 up, reading then checking
// each entry; delete follows the chain link by link, reading then checking each.
// Both walks run through the single read port of the allocation table memory.
module fat_chain_file_table_top
	import fct_pkg::*;
	#(
		parameter int CLUSTER_COUNT = CLUSTER_COUNT_DEF,
		parameter int SLOT_COUNT    = SLOT_COUNT_DEF
	)
	(
		input  logic         clk,
		input  logic         arst_n,
		input  logic         s_tvalid,
		output logic         s_tready,
		// file_name, byte_count, year, month, day, hour, minute, second, data_word
		input  logic [143:0] s_tdata,
		// action
		input  logic [2:0]   s_tuser,
		output logic         m_tvalid,
		input  logic         m_tready,
		// date_word, time_word, file_size, first_cluster, read_word
		output logic [103:0] m_tdata,
		// ok
		output logic         m_tuser,
		output logic         m_tlast
	);

	cmd_t  cmd;
	stat_t stat;

	logic [15:0] res_date, res_time;
	logic [31:0] res_size, res_word;
	logic [7:0]  res_first;

	fct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fct_dp #(
		.CLUSTER_COUNT (CLUSTER_COUNT),
		.SLOT_COUNT    (SLOT_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.res_ok    (m_tuser),
		.res_date  (res_date),
		.res_time  (res_time),
		.res_size  (res_size),
		.res_first (res_first),
		.res_word  (res_word),
		.res_end   (m_tlast)
	);

	assign m_tdata = {res_word, res_first, res_size, res_time, res_date};

	// a result word and an open input side never coexist
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while a result is pending");

	// a failed request carries nothing but zeros
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0 && !m_tlast))
		else $error("failed result carries data");

	// last-of-chain is only flagged on success
	a_last_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser)
		else $error("chain end flagged on failed request");

	// an accepted word is worked on before another is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second word accepted back to back");

endmodule

// ----- tb/fct_scoreboard.sv -----
// scoreboard for the file table: predicts each result and checks it against the block
package fct_tb_pkg;
	import fct_pkg::*;

	typedef struct {
		logic [2:0]  act;
		logic [63:0] name;
		logic [9:0]  bytes;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [31:0] data;
	} request_t;

	typedef struct {
		logic        ok;
		logic [15:0] date;
		logic [15:0] tod;
		logic [31:0] size;
		logic [7:0]  first;
		logic [31:0] rword;
		logic        cend;
	} reply_t;

	class fct_scoreboard;
		bit [15:0] links[256];
		bit [63:0] names[4];
		bit [15:0] dates[4];
		bit [15:0] tods[4];
		bit [31:0] sizes[4];
		bit [15:0] starts[4];
		bit [31:0] words[256];
		bit        stored[256];
		bit [15:0] wcur;
		bit [15:0] rcur;
		reply_t    awaited[$];
		int        errors;

		function new();
			foreach (links[i]) begin
				links[i] = 0;
				words[i] = 0;
				stored[i] = 0;
			end
			foreach (names[i]) begin
				names[i] = 0;
				dates[i] = 0;
				tods[i] = 0;
				sizes[i] = 0;
				starts[i] = 0;
			end
			wcur = CHAIN_END_MARK;
			rcur = CHAIN_END_MARK;
			errors = 0;
		endfunction

		function bit usable(bit [31:0] c);
			return c >= FIRST_USABLE && c < 256;
		endfunction

		function int find(bit [63:0] nm);
			for (int s = 0; s < 4; s++)
				if (names[s][7:0] != 0 && names[s] == nm)
					return s;
			return -1;
		endfunction

		function int free_clusters();
			int n;
			n = 0;
			for (int c = FIRST_USABLE; c < 256; c++)
				if (links[c] == 0)
					n++;
			return n;
		endfunction

		function int need_of(bit [9:0] b);
			int n;
			n = (32'(b) + 3) / 4;
			return n == 0 ? 1 : n;
		endfunction

		// read next must never land on a cluster that no put has filled
		function bit read_next_safe();
			return !usable(32'(rcur)) || stored[rcur[7:0]];
		endfunction

		function bit [15:0] cursor_of(bit [15:0] l);
			return usable(32'(l)) ? l : CHAIN_END_MARK;
		endfunction

		function void note(request_t rq);
			reply_t r;
			int s, need, prev, steps;
			bit [31:0] c, y;
			bit [15:0] l;
			r = '{default: 0};
			case (rq.act)
				ACT_CREATE: begin
					for (s = 0; s < 4; s++)
						if (names[s][7:0] == 0)
							break;
					if (s < 4 && free_clusters() >= need_of(rq.bytes)) begin
						names[s] = rq.name;
						r.ok = 1;
					end
				end
				ACT_WRITE: begin
					s = find(rq.name);
					need = need_of(rq.bytes);
					if (s >= 0 && free_clusters() >= need) begin
						prev = 0;
						for (int k = FIRST_USABLE; k < 256 && need > 0; k++) begin
							if (links[k] != 0)
								continue;
							if (prev != 0)
								links[prev] = 16'(k);
							else
								starts[s] = 16'(k);
							prev = k;
							need--;
						end
						links[prev] = CHAIN_END_MARK;
						y = 32'(rq.year) - 32'(BASE_YEAR);
						dates[s] = 16'((y << 9) + (32'(rq.month) << 5) + 32'(rq.day));
						tods[s] = 16'((32'(rq.hour) << 11) + (32'(rq.minute) << 5)
							+ 32'(rq.second) / 2);
						sizes[s] = 32'(rq.bytes);
						wcur = starts[s];
						r.ok = 1;
						r.date = dates[s];
						r.tod = tods[s];
						r.size = sizes[s];
						r.first = starts[s][7:0];
					end
				end
				ACT_PUT: begin
					if (usable(32'(wcur))) begin
						words[wcur[7:0]] = rq.data;
						stored[wcur[7:0]] = 1;
						wcur = cursor_of(links[wcur[7:0]]);
						r.ok = 1;
						r.cend = wcur == CHAIN_END_MARK;
					end
				end
				ACT_DELETE: begin
					s = find(rq.name);
					if (s >= 0) begin
						names[s][7:0] = 0;
						c = 32'(starts[s]);
						for (steps = 0; steps < 256 && usable(c); steps++) begin
							l = links[c[7:0]];
							links[c[7:0]] = 0;
							if (l == CHAIN_END_MARK || l == 0)
								break;
							c = 32'(l);
						end
						wcur = CHAIN_END_MARK;
						rcur = CHAIN_END_MARK;
						r.ok = 1;
					end
				end
				ACT_RD_HDR: begin
					s = find(rq.name);
					if (s >= 0) begin
						rcur = cursor_of(starts[s]);
						r.ok = 1;
						r.date = dates[s];
						r.tod = tods[s];
						r.size = sizes[s];
						r.first = starts[s][7:0];
					end
				end
				ACT_RD_NEXT: begin
					if (usable(32'(rcur))) begin
						r.rword = words[rcur[7:0]];
						rcur = cursor_of(links[rcur[7:0]]);
						r.ok = 1;
						r.cend = rcur == CHAIN_END_MARK;
					end
				end
				default: ;
			endcase
			awaited.push_back(r);
		endfunction

		function void check(reply_t got);
			reply_t e;
			if (awaited.size() == 0) begin
				$error("result with nothing awaited");
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (got.ok !== e.ok) begin
				$error("ok: expected %0h actual %0h", e.ok, got.ok);
				errors++;
			end
			if (got.date !== e.date) begin
				$error("date_word: expected %0h actual %0h", e.date, got.date);
				errors++;
			end
			if (got.tod !== e.tod) begin
				$error("time_word: expected %0h actual %0h", e.tod, got.tod);
				errors++;
			end
			if (got.size !== e.size) begin
				$error("file_size: expected %0h actual %0h", e.size, got.size);
				errors++;
			end
			if (got.first !== e.first) begin
				$error("first_cluster: expected %0h actual %0h", e.first, got.first);
				errors++;
			end
			if (got.rword !== e.rword) begin
				$error("read_word: expected %0h actual %0h", e.rword, got.rword);
				errors++;
			end
			if (got.cend !== e.cend) begin
				$error("chain_end: expected %0h actual %0h", e.cend, got.cend);
				errors++;
			end
		endfunction
	endclass
endpackage

// ----- tb/tb_top.sv -----
// top of the file table testbench: clock, reset, request driver and result monitor
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fct_pkg::*;
	import fct_tb_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;
	logic         m_tuser;
	logic         m_tlast;

	fct_scoreboard sb = new();
	logic [63:0]   pool[6];
	int            sent;
	bit            calm;

	fat_chain_file_table_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("Simulation FAILED");
		$finish;
	end

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// result side: sample the handshake of this edge, then pick the next tready
	always @(posedge clk or negedge arst_n) begin
		reply_t got;
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.ok = m_tuser;
				got.date = m_tdata[15:0];
				got.tod = m_tdata[31:16];
				got.size = m_tdata[63:32];
				got.first = m_tdata[71:64];
				got.rword = m_tdata[103:72];
				got.cend = m_tlast;
				sb.check(got);
			end
			m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) < 70);
		end
	end

	function request_t mk(logic [2:0] act, logic [63:0] nm, logic [9:0] b);
		request_t rq;
		rq.act = act;
		rq.name = nm;
		rq.bytes = b;
		rq.year = 12'($urandom_range(1980, 2107));
		rq.month = 4'($urandom_range(1, 12));
		rq.day = 5'($urandom_range(1, 31));
		rq.hour = 5'($urandom_range(0, 23));
		rq.minute = 6'($urandom_range(0, 59));
		rq.second = 6'($urandom_range(0, 59));
		rq.data = $urandom;
		return rq;
	endfunction

	task send(request_t rq);
		int g;
		if (rq.act == ACT_RD_NEXT && !sb.read_next_safe())
			return;
		s_tuser <= rq.act;
		s_tdata <= {rq.data, rq.second, rq.minute, rq.hour, rq.day, rq.month, rq.year,
			rq.bytes, rq.name};
		s_tvalid <= 1;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note(rq);
		sent++;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	function logic [9:0] rand_bytes();
		if ($urandom_range(0, 49) == 0)
			return 10'($urandom_range(0, 1016));
		return 10'($urandom_range(0, 40));
	endfunction

	initial begin
		request_t rq;
		int k, sel;
		logic [63:0] nm;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		sent = 0;
		calm = 0;
		for (int i = 0; i < 6; i++) begin
			pool[i] = {$urandom, $urandom};
			if (pool[i][7:0] == 0)
				pool[i][7:0] = 8'h41;
		end
		pool[5][7:0] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;

		// closed cursors, unknown codes, missing names
		send(mk(ACT_PUT, pool[0], 0));
		send(mk(ACT_RD_NEXT, pool[0], 0));
		send(mk(3'd6, pool[0], 0));
		send(mk(3'd7, '1, '1));
		send(mk(ACT_WRITE, pool[0], 4));
		send(mk(ACT_DELETE, pool[0], 4));
		send(mk(ACT_RD_HDR, pool[0], 4));
		// whole table in one chain, with extreme stamp
		send(mk(ACT_CREATE, '1, 1016));
		rq = mk(ACT_WRITE, '1, 1016);
		rq.year = 2107; rq.month = 12; rq.day = 31;
		rq.hour = 23; rq.minute = 59; rq.second = 59; rq.data = '1;
		send(rq);
		send(mk(ACT_CREATE, pool[1], 0));
		send(mk(ACT_WRITE, pool[1], 0));
		send(mk(ACT_PUT, '1, 0));
		send(mk(ACT_DELETE, '1, 0));
		// single-cluster write, low stamp, on a name not in the directory
		rq = mk(ACT_WRITE, pool[1], 0);
		rq.year = 1980; rq.month = 1; rq.day = 1;
		rq.hour = 0; rq.minute = 0; rq.second = 0; rq.data = 0;
		send(rq);
		rq.act = ACT_PUT;
		send(rq);
		send(mk(ACT_PUT, pool[1], 0));
		send(mk(ACT_RD_HDR, pool[1], 0));
		send(mk(ACT_RD_NEXT, pool[1], 0));
		send(mk(ACT_RD_NEXT, pool[1], 0));
		// empty-looking name, full directory
		send(mk(ACT_CREATE, pool[5], 8));
		send(mk(ACT_CREATE, pool[2], 8));
		send(mk(ACT_CREATE, pool[3], 8));
		send(mk(ACT_CREATE, pool[4], 8));
		send(mk(ACT_CREATE, pool[4], 8));
		send(mk(ACT_DELETE, pool[1], 0));

		while (sent < 850) begin
			if ($urandom_range(0, 19) == 0)
				calm = !calm;
			nm = pool[$urandom_range(0, 5)];
			sel = $urandom_range(0, 99);
			if (sel < 15) begin
				send(mk(ACT_CREATE, nm, rand_bytes()));
			end else if (sel < 45) begin
				rq = mk(ACT_WRITE, nm, rand_bytes());
				send(rq);
				k = $urandom_range(0, sb.need_of(rq.bytes) + 1);
				if (k > 12)
					k = 12;
				repeat (k) send(mk(ACT_PUT, nm, 0));
			end else if (sel < 70) begin
				send(mk(ACT_RD_HDR, nm, 0));
				k = $urandom_range(0, 6);
				repeat (k) send(mk(ACT_RD_NEXT, nm, 0));
			end else if (sel < 85) begin
				send(mk(ACT_DELETE, nm, 0));
			end else begin
				rq = mk(3'($urandom_range(0, 7)), {$urandom, $urandom}, 10'($urandom));
				rq.year = 12'($urandom_range(1980, 2107));
				if ($urandom_range(0, 1))
					rq.name = nm;
				send(rq);
			end
		end
		s_tvalid <= 0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/fct_pkg.sv
rtl/fct_ram.sv
rtl/fct_ctrl.sv
rtl/fct_dp.sv
rtl/fat_chain_file_table_top.sv
tb/fct_scoreboard.sv
tb/tb_top.sv
